// File: src/tpg_pkg.sv
package tpg_pkg;

    localparam int TAG8_W    = 8;
    localparam int DEV_W     = 16;
    localparam int CNT_W     = 8;
    localparam int CMD_W     = 3;
    localparam int DELAY_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESULT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_BUDGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_DELAY  = 2'd1;

    localparam logic [CNT_W-1:0]   BUDGET_RESET = 8'd10;
    localparam logic [DELAY_W-1:0] DELAY_RESET  = 32'd1000;
    localparam logic [CNT_W-1:0]   CNT_MAX      = 8'd255;

    // Status, sense key and additional sense code values.
    localparam logic [7:0] ST_CHECK       = 8'h02;
    localparam logic [7:0] ST_BUSY        = 8'h08;
    localparam logic [3:0] KEY_NOT_READY  = 4'h2;
    localparam logic [3:0] KEY_UNIT_ATTN  = 4'h6;
    localparam logic [7:0] ASC_BECOMING   = 8'h04;
    localparam logic [7:0] ASC_NO_SELECT  = 8'h05;
    localparam logic [7:0] SENSE_MIN      = 8'd13;

    typedef enum logic [1:0] {
        ACT_PROBE = 2'd0,
        ACT_UP    = 2'd1,
        ACT_DOWN  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        V_READY = 2'd0,
        V_NOW   = 2'd1,
        V_LATER = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DEV_W-1:0]  device_id;
        logic [TAG8_W-1:0] probe_tag;
        logic              transport_failed;
        logic              status_valid;
        logic [7:0]        scsi_status;
        logic [7:0]        sense_length;
        logic [7:0]        sense_byte_two;
        logic [7:0]        sense_code;
    } item_t;

    typedef struct packed {
        action_t           action;
        logic [DEV_W-1:0]  target_id;
        logic [TAG8_W-1:0] issued_tag;
        logic [CNT_W-1:0]  probe_count;
    } result_t;

endpackage

// File: src/tpg_judge.sv
module tpg_judge (
    input  tpg_pkg::item_t    item,
    output tpg_pkg::verdict_t verdict
);
    import tpg_pkg::*;

    logic [3:0] sense_key;

    assign sense_key = item.sense_byte_two[3:0];

    // Checks are ordered by priority: transport, status byte, then sense data.
    always_comb
    begin
        if (item.transport_failed)
            verdict = V_LATER;
        else if (!item.status_valid)
            verdict = V_READY;
        else if (item.scsi_status == ST_BUSY)
            verdict = V_LATER;
        else if (item.scsi_status != ST_CHECK)
            verdict = V_READY;
        else if (item.sense_length < SENSE_MIN)
            verdict = V_READY;
        else if (sense_key == KEY_UNIT_ATTN)
            verdict = V_NOW;
        else if (sense_key == KEY_NOT_READY &&
                 (item.sense_code == ASC_BECOMING || item.sense_code == ASC_NO_SELECT))
            verdict = V_LATER;
        else
            verdict = V_READY;
    end

endmodule

// File: src/tpg_gate.sv
module tpg_gate #(
    parameter int TAG_WIDTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  tpg_pkg::item_t                item,
    input  tpg_pkg::verdict_t             verdict,
    input  logic [tpg_pkg::CNT_W-1:0]     probe_budget,
    input  logic [tpg_pkg::DELAY_W-1:0]   retry_delay,
    output logic                          emit,
    output tpg_pkg::result_t              result
);
    import tpg_pkg::*;

    logic [TAG_WIDTH-1:0] run_tag_reg, run_tag_next, run_tag_inc;
    logic                 gate_active_reg, gate_active_next;
    logic                 announced_reg, announced_next;
    logic [CNT_W-1:0]     attempt_reg, attempt_next, attempt_inc;
    logic                 delay_running_reg, delay_running_next;
    logic [DELAY_W-1:0]   countdown_reg, countdown_next;
    logic [DEV_W-1:0]     held_device_reg, held_device_next;
    logic [TAG8_W-1:0]    cur_tag8, inc_tag8;

    assign run_tag_inc = run_tag_reg + {{(TAG_WIDTH-1){1'b0}}, 1'b1};
    assign attempt_inc = (attempt_reg == CNT_MAX) ? CNT_MAX : attempt_reg + 8'd1;

    // Results and probes see only the low byte of the run tag.
    generate
        if (TAG_WIDTH >= TAG8_W)
        begin : g_tag_wide
            assign cur_tag8 = run_tag_reg[TAG8_W-1:0];
            assign inc_tag8 = run_tag_inc[TAG8_W-1:0];
        end
        else
        begin : g_tag_narrow
            assign cur_tag8 = {{(TAG8_W-TAG_WIDTH){1'b0}}, run_tag_reg};
            assign inc_tag8 = {{(TAG8_W-TAG_WIDTH){1'b0}}, run_tag_inc};
        end
    endgenerate

    always_comb
    begin
        run_tag_next       = run_tag_reg;
        gate_active_next   = gate_active_reg;
        announced_next     = announced_reg;
        attempt_next       = attempt_reg;
        delay_running_next = delay_running_reg;
        countdown_next     = countdown_reg;
        held_device_next   = held_device_reg;
        emit               = 1'b0;
        result.action      = ACT_PROBE;
        result.target_id   = held_device_reg;
        result.issued_tag  = cur_tag8;
        result.probe_count = attempt_inc;

        unique case (item.cmd)
            CMD_DOWN:
            begin
                run_tag_next       = run_tag_inc;
                delay_running_next = 1'b0;
                countdown_next     = '0;
                gate_active_next   = 1'b0;
                announced_next     = 1'b0;
                emit               = 1'b1;
                result.action      = ACT_DOWN;
                result.target_id   = item.device_id;
                result.issued_tag  = '0;
                result.probe_count = '0;
            end
            CMD_UP:
            begin
                if (announced_reg)
                begin
                    emit               = 1'b1;
                    result.action      = ACT_UP;
                    result.target_id   = item.device_id;
                    result.issued_tag  = '0;
                    result.probe_count = attempt_reg;
                end
                else if (!gate_active_reg)
                begin
                    // A fresh run: the first probe goes out with the new tag.
                    gate_active_next   = 1'b1;
                    held_device_next   = item.device_id;
                    run_tag_next       = run_tag_inc;
                    attempt_next       = 8'd1;
                    emit               = 1'b1;
                    result.target_id   = item.device_id;
                    result.issued_tag  = inc_tag8;
                    result.probe_count = 8'd1;
                end
            end
            CMD_RESULT:
            begin
                if (item.probe_tag == cur_tag8 && gate_active_reg)
                begin
                    if (verdict == V_READY || attempt_reg >= probe_budget)
                    begin
                        gate_active_next   = 1'b0;
                        announced_next     = 1'b1;
                        delay_running_next = 1'b0;
                        countdown_next     = '0;
                        emit               = 1'b1;
                        result.action      = ACT_UP;
                        result.issued_tag  = '0;
                        result.probe_count = attempt_reg;
                    end
                    else if (verdict == V_NOW)
                    begin
                        attempt_next = attempt_inc;
                        emit         = 1'b1;
                    end
                    else
                    begin
                        delay_running_next = 1'b1;
                        countdown_next     = retry_delay;
                    end
                end
            end
            CMD_TICK:
            begin
                if (delay_running_reg)
                begin
                    if (countdown_reg > 32'd1)
                        countdown_next = countdown_reg - 32'd1;
                    else
                    begin
                        delay_running_next = 1'b0;
                        countdown_next     = '0;
                        if (gate_active_reg)
                        begin
                            attempt_next = attempt_inc;
                            emit         = 1'b1;
                        end
                    end
                end
            end
            CMD_CANCEL:
            begin
                run_tag_next       = run_tag_inc;
                delay_running_next = 1'b0;
                countdown_next     = '0;
                gate_active_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_tag_reg       <= '0;
            gate_active_reg   <= 1'b0;
            announced_reg     <= 1'b0;
            attempt_reg       <= '0;
            delay_running_reg <= 1'b0;
            countdown_reg     <= '0;
            held_device_reg   <= '0;
        end
        else if (step)
        begin
            run_tag_reg       <= run_tag_next;
            gate_active_reg   <= gate_active_next;
            announced_reg     <= announced_next;
            attempt_reg       <= attempt_next;
            delay_running_reg <= delay_running_next;
            countdown_reg     <= countdown_next;
            held_device_reg   <= held_device_next;
        end
    end

`ifndef SYNTH
    a_idle_countdown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !delay_running_reg |-> countdown_reg == '0)
        else $error("countdown nonzero with no delay running");

    a_gate_or_announced: assert property (@(posedge clk) disable iff (!rst_n)
        !(gate_active_reg && announced_reg))
        else $error("probe run active while target announced");

    a_run_has_probe: assert property (@(posedge clk) disable iff (!rst_n)
        gate_active_reg |-> attempt_reg != '0)
        else $error("active run without an issued probe");

    a_down_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.cmd == CMD_DOWN |=> !gate_active_reg && !announced_reg
            && !delay_running_reg)
        else $error("link down left gate state behind");
`endif

endmodule

// File: src/target_readiness_probe_gate_unit.sv
// Readiness gate for a storage target after login. Each request carries one event (link
// down, link up, probe result, tick or cancel) and yields at most one action: issue a
// readiness probe, announce the target up, or report it down. Probe results are
// classified from transport status, the status byte and autosense data; results whose tag
// does not match the current run are dropped. One request is taken every clock cycle while
// in_stall is low; a request passes an input register, is decided combinationally against
// the gate state, and its action is loaded into the output register when the request
// leaves the input register. The gate state is updated at that same edge, so back-to-back
// requests each see the effect of the one before. Configuration registers are written
// through the cfg port, which is always ready; write them only while no request is in
// flight.
module target_readiness_probe_gate_unit #(
    parameter int TAG_WIDTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tpg_pkg::CMD_W-1:0]         cmd,
    input  logic [tpg_pkg::DEV_W-1:0]         device_id,
    input  logic [tpg_pkg::TAG8_W-1:0]        probe_tag,
    input  logic                              transport_failed,
    input  logic                              status_valid,
    input  logic [7:0]                        scsi_status,
    input  logic [7:0]                        sense_length,
    input  logic [7:0]                        sense_byte_two,
    input  logic [7:0]                        sense_code,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        action,
    output logic [tpg_pkg::DEV_W-1:0]         target_id,
    output logic [tpg_pkg::TAG8_W-1:0]        issued_tag,
    output logic [tpg_pkg::CNT_W-1:0]         probe_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpg_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import tpg_pkg::*;

    logic               stage_valid_reg;
    item_t              stage_item_reg;
    logic               out_valid_reg;
    result_t            out_result_reg;
    logic [CNT_W-1:0]   budget_reg;
    logic [DELAY_W-1:0] delay_reg;

    logic     accept;
    logic     advance;
    logic     emit;
    result_t  result;
    verdict_t verdict;
    item_t    in_item;

    assign in_item.cmd              = cmd;
    assign in_item.device_id        = device_id;
    assign in_item.probe_tag        = probe_tag;
    assign in_item.transport_failed = transport_failed;
    assign in_item.status_valid     = status_valid;
    assign in_item.scsi_status      = scsi_status;
    assign in_item.sense_length     = sense_length;
    assign in_item.sense_byte_two   = sense_byte_two;
    assign in_item.sense_code       = sense_code;

    // The staged request moves on whenever the output register is free or being drained.
    assign advance  = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stage_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
            delay_reg  <= DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PROBE_BUDGET: budget_reg <= cfg_data[CNT_W-1:0];
                REG_RETRY_DELAY:  delay_reg  <= cfg_data[DELAY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (accept)
            stage_valid_reg <= 1'b1;
        else if (advance)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_item_reg <= in_item;
    end

    tpg_judge u_judge (
        .item    (stage_item_reg),
        .verdict (verdict)
    );

    tpg_gate #(
        .TAG_WIDTH (TAG_WIDTH)
    ) u_gate (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (stage_item_reg),
        .verdict      (verdict),
        .probe_budget (budget_reg),
        .retry_delay  (delay_reg),
        .emit         (emit),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_result_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign action      = out_result_reg.action;
    assign target_id   = out_result_reg.target_id;
    assign issued_tag  = out_result_reg.issued_tag;
    assign probe_count = out_result_reg.probe_count;

endmodule
